// File: src/csts_pkg.sv
// Shared constants, types and helpers of the cubic spline trajectory sampler.
package csts_pkg;

    localparam int MAX_POINTS = 16;
    localparam int AXES       = 6;
    localparam int PT_W       = 4;
    localparam int AX_W       = 3;
    localparam int CNT_W      = 5;
    localparam int TBL_DEPTH  = MAX_POINTS * AXES;
    localparam int TBL_AW     = 7;
    localparam int T_W        = 48;
    localparam int RES_W      = 56;
    localparam int MAG_W      = 50;
    localparam int HALF_W     = 25;
    localparam int BOP_W      = 33;
    localparam int ACC_W      = 84;
    localparam int PP_W       = HALF_W + BOP_W;

    localparam logic [31:0]      PERIOD_RESET = 32'd655;
    localparam logic [CNT_W-1:0] COUNT_RESET  = 5'd2;

    // Configuration register indexes.
    localparam logic CFG_PERIOD = 1'b0;
    localparam logic CFG_COUNT  = 1'b1;

    // Request codes.
    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    typedef enum logic [1:0] {
        JOB_ZERO,
        JOB_END,
        JOB_SEG
    } job_kind_t;

    typedef struct packed {
        job_kind_t        kind;
        logic [PT_W-1:0]  seg;
        logic [31:0]      tau;
        logic [31:0]      dur;
    } job_t;

    typedef struct packed {
        logic [AX_W-1:0] axis;
        logic [31:0]     pos;
        logic            last;
    } out_t;

    // Table address of one point and axis.
    function automatic logic [TBL_AW-1:0] tbl_addr(input logic [PT_W-1:0] pt,
                                                   input logic [AX_W-1:0] ax);
        tbl_addr = TBL_AW'(pt) * TBL_AW'(AXES) + TBL_AW'(ax);
    endfunction

endpackage

// File: src/csts_ram.sv
// Generic simple dual-port RAM with registered read.
module csts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/csts_front.sv
// Front end: takes words, writes waypoints and searches for the segment of a sample.
module csts_front import csts_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic              req_type,
    input  logic [PT_W-1:0]   point_index,
    input  logic [AX_W-1:0]   axis_index,
    input  logic [31:0]       point_time,
    input  logic [31:0]       point_pos,
    input  logic [31:0]       point_vel,
    input  logic [15:0]       sample_index,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [31:0]       cfg_data,
    input  logic              back_idle,
    input  logic              jobq_full,
    output logic              job_push,
    output job_t              job,
    output logic              tbl_we,
    output logic [TBL_AW-1:0] tbl_waddr,
    output logic [31:0]       pos_wdata,
    output logic [31:0]       vel_wdata
);

    typedef enum logic [1:0] {
        F_IDLE,
        F_LOAD,
        F_SEARCH,
        F_PUSH
    } fstate_t;

    fstate_t          state_reg, state_next;
    logic [31:0]      period_reg, period_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [CNT_W-1:0] issue_reg, issue_next;
    logic             dv_reg, dv_next;
    logic [PT_W-1:0]  di_reg, di_next;
    logic             found_reg, found_next;
    logic             end_reg, end_next;
    logic [PT_W-1:0]  ld_point_reg, ld_point_next;
    logic [AX_W-1:0]  ld_axis_reg, ld_axis_next;
    logic [31:0]      ld_time_reg, ld_time_next;
    logic [31:0]      ld_pos_reg, ld_pos_next;
    logic [31:0]      ld_vel_reg, ld_vel_next;
    logic [T_W-1:0]   t_reg, t_next;
    logic [31:0]      prev_reg, prev_next;
    logic [PT_W-1:0]  seg_reg, seg_next;
    logic [31:0]      tau_reg, tau_next;
    logic [31:0]      dur_reg, dur_next;

    logic             time_re;
    logic [31:0]      time_rdata;
    logic [PT_W-1:0]  last_idx;
    logic [CNT_W-1:0] n_clamp;

    // Waypoint times, read one entry a cycle during the search.
    csts_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_time_ram (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (ld_point_reg),
        .wdata (ld_time_reg),
        .re    (time_re),
        .raddr (issue_reg[PT_W-1:0]),
        .rdata (time_rdata)
    );

    assign last_idx  = PT_W'(n_reg - CNT_W'(1));
    assign tbl_waddr = tbl_addr(ld_point_reg, ld_axis_reg);
    assign pos_wdata = ld_pos_reg;
    assign vel_wdata = ld_vel_reg;

    // Point count held to the usable range.
    always_comb
    begin
        if (count_reg < CNT_W'(2))
        begin
            n_clamp = CNT_W'(2);
        end
        else if (count_reg > CNT_W'(MAX_POINTS))
        begin
            n_clamp = CNT_W'(MAX_POINTS);
        end
        else
        begin
            n_clamp = count_reg;
        end
    end

    // Job handed to the back end; the final time wins over any segment.
    always_comb
    begin
        job.tau = tau_reg;
        job.dur = dur_reg;
        if (end_reg)
        begin
            job.kind = JOB_END;
            job.seg  = last_idx;
        end
        else if (found_reg)
        begin
            job.kind = JOB_SEG;
            job.seg  = seg_reg;
        end
        else
        begin
            job.kind = JOB_ZERO;
            job.seg  = seg_reg;
        end
    end

    // Sequencer of the front end.
    always_comb
    begin
        state_next    = state_reg;
        period_next   = period_reg;
        count_next    = count_reg;
        n_next        = n_reg;
        issue_next    = issue_reg;
        dv_next       = 1'b0;
        di_next       = issue_reg[PT_W-1:0];
        found_next    = found_reg;
        end_next      = end_reg;
        ld_point_next = ld_point_reg;
        ld_axis_next  = ld_axis_reg;
        ld_time_next  = ld_time_reg;
        ld_pos_next   = ld_pos_reg;
        ld_vel_next   = ld_vel_reg;
        t_next        = t_reg;
        prev_next     = prev_reg;
        seg_next      = seg_reg;
        tau_next      = tau_reg;
        dur_next      = dur_reg;
        full          = (state_reg != F_IDLE);
        time_re       = 1'b0;
        tbl_we        = 1'b0;
        job_push      = 1'b0;

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PERIOD: period_next = cfg_data;
                CFG_COUNT:  count_next  = cfg_data[CNT_W-1:0];
            endcase
        end

        unique case (state_reg)
            F_IDLE:
            begin
                if (push)
                begin
                    ld_point_next = point_index;
                    ld_axis_next  = axis_index;
                    ld_time_next  = point_time;
                    ld_pos_next   = point_pos;
                    ld_vel_next   = point_vel;
                    t_next        = T_W'(sample_index) * T_W'(period_reg);
                    n_next        = n_clamp;
                    issue_next    = '0;
                    found_next    = 1'b0;
                    end_next      = 1'b0;
                    if (req_type == REQ_LOAD)
                    begin
                        state_next = F_LOAD;
                    end
                    else
                    begin
                        state_next = F_SEARCH;
                    end
                end
            end
            F_LOAD:
            begin
                // Tables change only while no sample is in the back end.
                if (back_idle)
                begin
                    tbl_we     = (ld_axis_reg < AX_W'(AXES));
                    state_next = F_IDLE;
                end
            end
            F_SEARCH:
            begin
                if (issue_reg < n_reg)
                begin
                    time_re    = 1'b1;
                    issue_next = issue_reg + CNT_W'(1);
                end
                dv_next = time_re;
                if (dv_reg)
                begin
                    prev_next = time_rdata;
                    if (di_reg != '0 && t_reg >= {16'b0, prev_reg}
                        && t_reg < {16'b0, time_rdata})
                    begin
                        found_next = 1'b1;
                        seg_next   = di_reg - PT_W'(1);
                        tau_next   = t_reg[31:0] - prev_reg;
                        dur_next   = time_rdata - prev_reg;
                    end
                    if (di_reg == last_idx)
                    begin
                        end_next   = (t_reg == {16'b0, time_rdata});
                        state_next = F_PUSH;
                    end
                end
            end
            F_PUSH:
            begin
                if (!jobq_full)
                begin
                    job_push   = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    // Control state and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= F_IDLE;
            period_reg <= PERIOD_RESET;
            count_reg  <= COUNT_RESET;
            dv_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            period_reg <= period_next;
            count_reg  <= count_next;
            dv_reg     <= dv_next;
        end
    end

    // Working registers of the search.
    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        issue_reg    <= issue_next;
        di_reg       <= di_next;
        found_reg    <= found_next;
        end_reg      <= end_next;
        ld_point_reg <= ld_point_next;
        ld_axis_reg  <= ld_axis_next;
        ld_time_reg  <= ld_time_next;
        ld_pos_reg   <= ld_pos_next;
        ld_vel_reg   <= ld_vel_next;
        t_reg        <= t_next;
        prev_reg     <= prev_next;
        seg_reg      <= seg_next;
        tau_reg      <= tau_next;
        dur_reg      <= dur_next;
    end

endmodule

// File: src/csts_jobq.sv
// Two-entry queue of jobs between the front and back ends.
module csts_jobq import csts_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic wr,
    input  job_t wr_job,
    input  logic rd,
    output job_t rd_job,
    output logic empty,
    output logic full
);

    job_t       slot_reg [2];
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_wr, do_rd;

    assign empty  = (cnt_reg == 2'd0);
    assign full   = (cnt_reg == 2'd2);
    assign do_wr  = wr && !full;
    assign do_rd  = rd && !empty;
    assign rd_job = slot_reg[rp_reg];

    // Pointer and count update.
    always_comb
    begin
        wp_next  = wp_reg ^ do_wr;
        rp_next  = rp_reg ^ do_rd;
        cnt_next = cnt_reg + 2'(do_wr) - 2'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wp_reg] <= wr_job;
        end
    end

endmodule

// File: src/csts_back.sv
// Back end: divider, shared multiply unit, per-axis cubic evaluation and result buffer.
module csts_back import csts_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              jobq_empty,
    input  job_t              jobq_word,
    output logic              jobq_pop,
    output logic              idle,
    output logic              tbl_re,
    output logic [TBL_AW-1:0] tbl_raddr,
    input  logic [31:0]       pos_rdata,
    input  logic [31:0]       vel_rdata,
    output logic              empty,
    input  logic              pop,
    output logic [AX_W-1:0]   out_axis,
    output logic [31:0]       position,
    output logic              last
);

    typedef enum logic [3:0] {
        B_IDLE,
        B_ZERO,
        B_END_RD,
        B_END_OUT,
        B_DIV,
        B_SQ1,
        B_SQ2,
        B_HG,
        B_RD0,
        B_RD1,
        B_RD2,
        B_MSET,
        B_MLO,
        B_MHI,
        B_MFIN,
        B_SUM
    } bstate_t;

    bstate_t                 state_reg, state_next;
    logic [AX_W-1:0]         ax_reg, ax_next;
    logic [PT_W-1:0]         seg_reg, seg_next;
    logic [31:0]             tau_reg, tau_next;
    logic [31:0]             dur_reg, dur_next;
    logic [4:0]              div_cnt_reg, div_cnt_next;
    logic [32:0]             rem_reg, rem_next;
    logic [30:0]             q_reg, q_next;
    logic [30:0]             s2_reg, s2_next;
    logic [30:0]             s3_reg, s3_next;
    logic [BOP_W-1:0]        h_reg, h_next;
    logic [30:0]             g_reg, g_next;
    logic signed [31:0]      p0_reg, p0_next;
    logic signed [31:0]      p1_reg, p1_next;
    logic signed [31:0]      v0_reg, v0_next;
    logic signed [31:0]      v1_reg, v1_next;
    logic [2:0]              op_reg, op_next;
    logic [MAG_W-1:0]        mag_reg, mag_next;
    logic                    neg_reg, neg_next;
    logic [BOP_W-1:0]        bop_reg, bop_next;
    logic                    sh16_reg, sh16_next;
    logic [ACC_W-1:0]        acc_reg, acc_next;
    logic signed [RES_W-1:0] a_reg, a_next;
    logic signed [RES_W-1:0] b_reg, b_next;
    logic signed [RES_W-1:0] w_reg, w_next;
    logic signed [RES_W-1:0] t1_reg, t1_next;
    logic signed [RES_W-1:0] t2_reg, t2_next;

    out_t                    buf_reg [4];
    logic [1:0]              wp_reg, rp_reg;
    logic [2:0]              cnt_reg;
    logic                    ofull, opush, opop;
    out_t                    oword;

    logic [32:0]             rem2;
    logic [61:0]             sq_prod;
    logic [PP_W-1:0]         pp;
    logic signed [RES_W-1:0] x_sel;
    logic [RES_W-1:0]        x_abs;
    logic [ACC_W-1:0]        shifted;
    logic signed [RES_W-1:0] mres;
    logic signed [RES_W-1:0] sum;
    logic [31:0]             sat_pos;
    logic                    ax_last;

    assign ax_last = (ax_reg == AX_W'(AXES - 1));
    assign rem2    = {rem_reg[31:0], 1'b0};
    assign idle    = (state_reg == B_IDLE);

    // Datapath helpers: square product, partial product, operand select, result scaling.
    always_comb
    begin
        if (state_reg == B_SQ1)
        begin
            sq_prod = 62'(q_reg) * 62'(q_reg);
        end
        else
        begin
            sq_prod = 62'(s2_reg) * 62'(q_reg);
        end

        if (state_reg == B_MLO)
        begin
            pp = mag_reg[HALF_W-1:0] * bop_reg;
        end
        else
        begin
            pp = mag_reg[MAG_W-1:HALF_W] * bop_reg;
        end

        unique case (op_reg)
            3'd0, 3'd1: x_sel = RES_W'(v0_reg);
            3'd2:       x_sel = RES_W'(v1_reg) - RES_W'(v0_reg);
            3'd3:       x_sel = RES_W'(p1_reg) - RES_W'(p0_reg) - b_reg;
            default:    x_sel = w_reg;
        endcase
        x_abs = x_sel[RES_W-1] ? RES_W'(-x_sel) : RES_W'(x_sel);

        if (sh16_reg)
        begin
            shifted = acc_reg >> 16;
        end
        else
        begin
            shifted = acc_reg >> 31;
        end
        mres = neg_reg ? -signed'(shifted[RES_W-1:0]) : signed'(shifted[RES_W-1:0]);

        sum = RES_W'(p0_reg) + a_reg + t1_reg - t2_reg;
        if (sum[RES_W-1:31] != '0 && sum[RES_W-1:31] != '1)
        begin
            sat_pos = sum[RES_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        else
        begin
            sat_pos = sum[31:0];
        end
    end

    // Sequencer of the back end.
    always_comb
    begin
        state_next   = state_reg;
        ax_next      = ax_reg;
        seg_next     = seg_reg;
        tau_next     = tau_reg;
        dur_next     = dur_reg;
        div_cnt_next = div_cnt_reg;
        rem_next     = rem_reg;
        q_next       = q_reg;
        s2_next      = s2_reg;
        s3_next      = s3_reg;
        h_next       = h_reg;
        g_next       = g_reg;
        p0_next      = p0_reg;
        p1_next      = p1_reg;
        v0_next      = v0_reg;
        v1_next      = v1_reg;
        op_next      = op_reg;
        mag_next     = mag_reg;
        neg_next     = neg_reg;
        bop_next     = bop_reg;
        sh16_next    = sh16_reg;
        acc_next     = acc_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        w_next       = w_reg;
        t1_next      = t1_reg;
        t2_next      = t2_reg;
        jobq_pop     = 1'b0;
        tbl_re       = 1'b0;
        tbl_raddr    = tbl_addr(seg_reg, ax_reg);
        opush        = 1'b0;
        oword.axis   = ax_reg;
        oword.pos    = '0;
        oword.last   = ax_last;

        unique case (state_reg)
            B_IDLE:
            begin
                if (!jobq_empty)
                begin
                    jobq_pop     = 1'b1;
                    seg_next     = jobq_word.seg;
                    tau_next     = jobq_word.tau;
                    dur_next     = jobq_word.dur;
                    ax_next      = '0;
                    rem_next     = {1'b0, jobq_word.tau};
                    q_next       = '0;
                    div_cnt_next = '0;
                    unique case (jobq_word.kind)
                        JOB_END: state_next = B_END_RD;
                        JOB_SEG: state_next = B_DIV;
                        default: state_next = B_ZERO;
                    endcase
                end
            end
            B_ZERO:
            begin
                if (!ofull)
                begin
                    opush      = 1'b1;
                    ax_next    = ax_reg + AX_W'(1);
                    state_next = ax_last ? B_IDLE : B_ZERO;
                end
            end
            B_END_RD:
            begin
                tbl_re     = 1'b1;
                state_next = B_END_OUT;
            end
            B_END_OUT:
            begin
                oword.pos = pos_rdata;
                if (!ofull)
                begin
                    opush      = 1'b1;
                    ax_next    = ax_reg + AX_W'(1);
                    state_next = ax_last ? B_IDLE : B_END_RD;
                end
            end
            B_DIV:
            begin
                // Restoring division, one quotient bit a cycle.
                if (rem2 >= {1'b0, dur_reg})
                begin
                    rem_next = rem2 - {1'b0, dur_reg};
                    q_next   = {q_reg[29:0], 1'b1};
                end
                else
                begin
                    rem_next = rem2;
                    q_next   = {q_reg[29:0], 1'b0};
                end
                div_cnt_next = div_cnt_reg + 5'd1;
                if (div_cnt_reg == 5'd30)
                begin
                    state_next = B_SQ1;
                end
            end
            B_SQ1:
            begin
                s2_next    = sq_prod[61:31];
                state_next = B_SQ2;
            end
            B_SQ2:
            begin
                s3_next    = sq_prod[61:31];
                state_next = B_HG;
            end
            B_HG:
            begin
                h_next     = BOP_W'(s2_reg) * BOP_W'(3) - BOP_W'(s3_reg) * BOP_W'(2);
                g_next     = s2_reg - s3_reg;
                state_next = B_RD0;
            end
            B_RD0:
            begin
                tbl_re     = 1'b1;
                state_next = B_RD1;
            end
            B_RD1:
            begin
                tbl_re     = 1'b1;
                tbl_raddr  = tbl_addr(seg_reg + PT_W'(1), ax_reg);
                p0_next    = signed'(pos_rdata);
                v0_next    = signed'(vel_rdata);
                state_next = B_RD2;
            end
            B_RD2:
            begin
                p1_next    = signed'(pos_rdata);
                v1_next    = signed'(vel_rdata);
                op_next    = '0;
                state_next = B_MSET;
            end
            B_MSET:
            begin
                neg_next = x_sel[RES_W-1];
                mag_next = x_abs[MAG_W-1:0];
                unique case (op_reg)
                    3'd0:
                    begin
                        bop_next  = BOP_W'(tau_reg);
                        sh16_next = 1'b1;
                    end
                    3'd1, 3'd2:
                    begin
                        bop_next  = BOP_W'(dur_reg);
                        sh16_next = 1'b1;
                    end
                    3'd3:
                    begin
                        bop_next  = h_reg;
                        sh16_next = 1'b0;
                    end
                    default:
                    begin
                        bop_next  = BOP_W'(g_reg);
                        sh16_next = 1'b0;
                    end
                endcase
                state_next = B_MLO;
            end
            B_MLO:
            begin
                acc_next   = ACC_W'(pp);
                state_next = B_MHI;
            end
            B_MHI:
            begin
                acc_next   = acc_reg + (ACC_W'(pp) << HALF_W);
                state_next = B_MFIN;
            end
            B_MFIN:
            begin
                unique case (op_reg)
                    3'd0:    a_next  = mres;
                    3'd1:    b_next  = mres;
                    3'd2:    w_next  = mres;
                    3'd3:    t1_next = mres;
                    default: t2_next = mres;
                endcase
                op_next    = op_reg + 3'd1;
                state_next = (op_reg == 3'd4) ? B_SUM : B_MSET;
            end
            B_SUM:
            begin
                oword.pos = sat_pos;
                if (!ofull)
                begin
                    opush      = 1'b1;
                    ax_next    = ax_reg + AX_W'(1);
                    state_next = ax_last ? B_IDLE : B_RD0;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Result buffer, four words deep.
    assign ofull    = (cnt_reg == 3'd4);
    assign empty    = (cnt_reg == 3'd0);
    assign opop     = pop && !empty;
    assign out_axis = buf_reg[rp_reg].axis;
    assign position = buf_reg[rp_reg].pos;
    assign last     = buf_reg[rp_reg].last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            wp_reg    <= '0;
            rp_reg    <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            wp_reg    <= wp_reg + 2'(opush);
            rp_reg    <= rp_reg + 2'(opop);
            cnt_reg   <= cnt_reg + 3'(opush) - 3'(opop);
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (opush)
        begin
            buf_reg[wp_reg] <= oword;
        end
        ax_reg      <= ax_next;
        seg_reg     <= seg_next;
        tau_reg     <= tau_next;
        dur_reg     <= dur_next;
        div_cnt_reg <= div_cnt_next;
        rem_reg     <= rem_next;
        q_reg       <= q_next;
        s2_reg      <= s2_next;
        s3_reg      <= s3_next;
        h_reg       <= h_next;
        g_reg       <= g_next;
        p0_reg      <= p0_next;
        p1_reg      <= p1_next;
        v0_reg      <= v0_next;
        v1_reg      <= v1_next;
        op_reg      <= op_next;
        mag_reg     <= mag_next;
        neg_reg     <= neg_next;
        bop_reg     <= bop_next;
        sh16_reg    <= sh16_next;
        acc_reg     <= acc_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        w_reg       <= w_next;
        t1_reg      <= t1_next;
        t2_reg      <= t2_next;
    end

endmodule

// File: src/cubic_spline_trajectory_sampler.sv
// Cubic Hermite trajectory sampler over a loaded waypoint table (Q16.16).
//
// Input words enter with push while full is low. A load word writes the time of one
// waypoint and the position and velocity of one axis; it yields no result. A sample
// word gives a sample index; the block yields one result word per axis, axis 0 first,
// with last set on the final axis. Results are read with pop while empty is low.
// Configuration (sample period, point count) is to be written through cfg_we,
// cfg_index and cfg_data while the block is idle; the block does not enforce this.
// A load waits while a sample is queued or being evaluated, then writes the tables.
// The segment search reads one waypoint time a cycle. Evaluation then gives a zero result
// per axis for a time outside every segment, and the final waypoint's positions at the
// final time; inside a segment it runs a one-bit-a-cycle division, then per axis two
// table reads and five products on the shared multiply unit. A two-entry job queue
// lets the next search run while the previous sample is evaluated. A four-word
// result buffer absorbs short stalls on pop; a longer stall holds the evaluation
// and then the front end.
// Reset clears the control state and sets the period to 655 and the count to two;
// the waypoint tables hold nothing valid until loaded.
module cubic_spline_trajectory_sampler import csts_pkg::*; (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  logic            req_type,
    input  logic [PT_W-1:0] point_index,
    input  logic [AX_W-1:0] axis_index,
    input  logic [31:0]     point_time,
    input  logic [31:0]     point_pos,
    input  logic [31:0]     point_vel,
    input  logic [15:0]     sample_index,
    output logic            empty,
    input  logic            pop,
    output logic [AX_W-1:0] out_axis,
    output logic [31:0]     position,
    output logic            last,
    input  logic            cfg_we,
    input  logic            cfg_index,
    input  logic [31:0]     cfg_data
);

    job_t              fr_job, q_job;
    logic              job_push, job_pop, jobq_full, jobq_empty;
    logic              back_free, back_idle;
    logic              tbl_we, tbl_re;
    logic [TBL_AW-1:0] tbl_waddr, tbl_raddr;
    logic [31:0]       pos_wdata, vel_wdata, pos_rdata, vel_rdata;

    assign back_idle = back_free && jobq_empty;

    // Front end: accepts words and searches segments.
    csts_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .req_type     (req_type),
        .point_index  (point_index),
        .axis_index   (axis_index),
        .point_time   (point_time),
        .point_pos    (point_pos),
        .point_vel    (point_vel),
        .sample_index (sample_index),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .back_idle    (back_idle),
        .jobq_full    (jobq_full),
        .job_push     (job_push),
        .job          (fr_job),
        .tbl_we       (tbl_we),
        .tbl_waddr    (tbl_waddr),
        .pos_wdata    (pos_wdata),
        .vel_wdata    (vel_wdata)
    );

    // Jobs waiting for evaluation.
    csts_jobq u_jobq (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (job_push),
        .wr_job (fr_job),
        .rd     (job_pop),
        .rd_job (q_job),
        .empty  (jobq_empty),
        .full   (jobq_full)
    );

    // Per-axis waypoint positions and velocities.
    csts_ram #(.WIDTH(32), .DEPTH(TBL_DEPTH)) u_pos_ram (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (pos_wdata),
        .re    (tbl_re),
        .raddr (tbl_raddr),
        .rdata (pos_rdata)
    );

    csts_ram #(.WIDTH(32), .DEPTH(TBL_DEPTH)) u_vel_ram (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (vel_wdata),
        .re    (tbl_re),
        .raddr (tbl_raddr),
        .rdata (vel_rdata)
    );

    // Back end: evaluation and result buffer.
    csts_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .jobq_empty (jobq_empty),
        .jobq_word  (q_job),
        .jobq_pop   (job_pop),
        .idle       (back_free),
        .tbl_re     (tbl_re),
        .tbl_raddr  (tbl_raddr),
        .pos_rdata  (pos_rdata),
        .vel_rdata  (vel_rdata),
        .empty      (empty),
        .pop        (pop),
        .out_axis   (out_axis),
        .position   (position),
        .last       (last)
    );

endmodule
